// File: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, constants and round functions of the byte-stream sha-256 hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] INIT_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: design/sha256_msg_if.sv
// ----------------------------------------------------------------------------
// sha256_msg_if
// message channel: one byte or a finish command per word
// ----------------------------------------------------------------------------
interface sha256_msg_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: design/sha256_digest_if.sv
// ----------------------------------------------------------------------------
// sha256_digest_if
// digest channel: one 32-bit digest word per word
// ----------------------------------------------------------------------------
interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// File: design/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 engine fed one message byte per word, one round per cycle
// ----------------------------------------------------------------------------
// usage
//   msg channel: kind 0 absorbs data_byte, kind 1 ends the message. the
//   hasher pads the message, then sends the digest on the digest channel as
//   eight words, word_index 0..7, most significant first, last_word on 7.
// flow
//   a byte that does not complete a 64-byte block leaves msg.ready high.
//   a byte that completes a block starts the compression: 64 rounds on
//   the single shared round unit, then a fold into the chaining words,
//   before msg.ready returns. long message throughput is set by the
//   one-round-per-cycle loop.
//   finish: padding is shifted in byte by byte (marker, zeros, eight
//   length bytes), then one or two compressions, then the eight digest
//   words.
// reset and stalls
//   rst_n clears the chaining words to the sha-256 initial values and
//   empties the byte count. msg.ready is low while a block is compressed,
//   while padding, and while the digest is out. if the digest receiver
//   stalls, the current word holds; after the last word is taken the
//   state is back to its initial values and the next message can start.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic                   clk,
    input  logic                   rst_n,
    sha256_msg_if.sink             msg,
    sha256_digest_if.source        digest
);
    import sha256_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;       // bytes pending in the block
    logic [63:0] bits_reg, bits_next;     // message length in bits
    logic [5:0]  rnd_reg, rnd_next;       // compression round
    logic [2:0]  idx_reg, idx_next;       // digest word being sent
    logic        pad_reg, pad_next;       // padding under way
    logic        final_reg, final_next;   // length written, last block

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] work_reg [8];            // a..h
    logic [31:0] work_next [8];
    logic [31:0] win_reg [16];            // block bytes, then schedule window

    logic        msg_acc;
    logic        dig_acc;
    logic        byte_shift;
    logic [7:0]  byte_val;
    logic        word_shift;

    logic [31:0] w_new;
    logic [31:0] w_t;
    logic [31:0] ch_val;
    logic [31:0] maj_val;
    logic [31:0] t1;
    logic [31:0] t2;

    assign msg_acc = msg.valid && msg.ready;
    assign dig_acc = digest.valid && digest.ready;

    // shared round unit: message schedule and one compression round
    assign w_new = small_sigma1(win_reg[14]) + win_reg[9]
                 + small_sigma0(win_reg[1]) + win_reg[0];
    // first 16 rounds take the block words as they rotate through the window
    assign w_t   = (rnd_reg[5:4] == 2'b00) ? win_reg[0] : w_new;
    assign ch_val  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj_val = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                   ^ (work_reg[1] & work_reg[2]);
    assign t1 = work_reg[7] + big_sigma1(work_reg[4]) + ch_val + ROUND_K[rnd_reg] + w_t;
    assign t2 = big_sigma0(work_reg[0]) + maj_val;

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        final_next = final_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        byte_shift = 1'b0;
        byte_val   = msg.data_byte;
        word_shift = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    if (msg.kind == KIND_ABSORB)
                    begin
                        byte_shift = 1'b1;
                        bits_next  = bits_reg + BITS_PER_BYTE;
                        pos_next   = pos_reg + 6'd1;
                        if (pos_reg == LAST_BYTE_POS)
                        begin
                            work_next  = chain_reg;
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        pad_next   = 1'b1;
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                byte_shift = 1'b1;
                byte_val   = PAD_MARK_BYTE;
                pos_next   = pos_reg + 6'd1;
                if (pos_reg == LAST_BYTE_POS)
                begin
                    work_next  = chain_reg;
                    state_next = ST_ROUND;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (pos_reg == LEN_FIELD_POS)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    byte_shift = 1'b1;
                    byte_val   = PAD_ZERO_BYTE;
                    pos_next   = pos_reg + 6'd1;
                    if (pos_reg == LAST_BYTE_POS)
                    begin
                        work_next  = chain_reg;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                // big-endian length, shifted out of the bit counter
                byte_shift = 1'b1;
                byte_val   = bits_reg[63:56];
                bits_next  = {bits_reg[55:0], 8'h00};
                pos_next   = pos_reg + 6'd1;
                if (pos_reg == LAST_BYTE_POS)
                begin
                    final_next = 1'b1;
                    work_next  = chain_reg;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                word_shift   = 1'b1;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                priority if (final_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD_ZERO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (dig_acc)
                begin
                    // shift the digest down and feed the initial values in behind
                    for (int i = 0; i < 7; i++)
                    begin
                        chain_next[i] = chain_reg[i + 1];
                    end
                    chain_next[7] = INIT_CHAIN[idx_reg];
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD_IDX)
                    begin
                        pos_next   = 6'd0;
                        bits_next  = 64'd0;
                        pad_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 6'd0;
            bits_reg  <= 64'd0;
            rnd_reg   <= 6'd0;
            idx_reg   <= 3'd0;
            pad_reg   <= 1'b0;
            final_reg <= 1'b0;
            chain_reg <= INIT_CHAIN;
        end
        else
        begin
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            final_reg <= final_next;
            chain_reg <= chain_next;
        end
    end

    // working variables, no reset needed
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    // block window: bytes shift in at the low end, rounds shift whole words
    always_ff @(posedge clk)
    begin
        if (byte_shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], byte_val};
        end
        else if (word_shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_t;
        end
    end

    assign msg.ready          = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain_reg[0];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == LAST_WORD_IDX);

    // the two channels never handshake at once
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg.ready && digest.valid))
        else $error("message and digest channels active together");

    // a byte that fills the block starts a compression
    a_block_compress: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_acc && msg.kind == KIND_ABSORB && pos_reg == LAST_BYTE_POS)
        |=> (state_reg == ST_ROUND && rnd_reg == 6'd0))
        else $error("full block did not start compression");

    // a finish blocks further input and the digest does not appear at once
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_acc && msg.kind == KIND_FINISH) |=> (!msg.ready && !digest.valid))
        else $error("finish not followed by padding");

    // after the last digest word the hasher is clean and ready again
    a_clean_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_acc && digest.last_word)
        |=> (msg.ready && pos_reg == 6'd0 && bits_reg == 64'd0
             && chain_reg[0] == INIT_CHAIN[0]))
        else $error("state not restored after digest");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the byte-stream sha-256 hasher
//
// message words go in one per handshake. The testbench keeps its own sha-256
// model: the chaining words, the pending block, the fill count and the bit
// count. Every finish word that is accepted queues the eight expected digest
// words. A checker compares each digest word taken from the hasher with the
// oldest expected word. Directed messages come first, then random messages
// under four idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha256_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    // random part runs until both counts are reached
    localparam int RANDOM_WORDS   = 130;
    localparam int RANDOM_DIGESTS = 6;
    localparam int DRAIN_CYCLES   = 200;
    // cycles in a row with no handshake on either channel
    localparam int WATCHDOG_LIMIT = 5000;

    // message lengths around the padding and block edges
    localparam int EDGE_LEN [6] = '{55, 56, 57, 63, 64, 65};

    // sha-256 round constants
    localparam logic [31:0] round_const [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // sha-256 initial chaining value
    localparam logic [31:0] chain_iv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    sha256_msg_if    msg_ch ();
    sha256_digest_if dig_ch ();

    sha256_byte_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // model state of the hasher
    logic [31:0] hash_chain [8];
    logic [7:0]  hash_block [64];
    logic [5:0]  hash_fill;
    logic [63:0] hash_bits;

    // digest words still owed by the hasher, oldest first
    digest_entry_t owed_digest_words [$];

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int words_sent     = 0;
    int digests_owed   = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    // ------------------------------------------------------------------------
    // sha-256 model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_chain[i] = chain_iv[i];
        hash_fill = '0;
        hash_bits = '0;
    endfunction

    // one 64-round compression of hash_block into hash_chain
    function automatic void compress_hash_block();
        logic [31:0] win [16];
        logic [31:0] v [8];
        logic [31:0] w;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] m2;
        logic [31:0] m15;
        int r;
        for (r = 0; r < 8; r++)
            v[r] = hash_chain[r];
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
                w = {hash_block[4 * r], hash_block[4 * r + 1],
                     hash_block[4 * r + 2], hash_block[4 * r + 3]};
            else
            begin
                // rolling 16-entry schedule window
                m2  = win[(r - 2) & 15];
                m15 = win[(r - 15) & 15];
                w = (ror32(m2, 17) ^ ror32(m2, 19) ^ (m2 >> 10)) + win[(r - 7) & 15]
                  + (ror32(m15, 7) ^ ror32(m15, 18) ^ (m15 >> 3)) + win[r & 15];
            end
            win[r & 15] = w;
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[r] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++)
            hash_chain[r] = hash_chain[r] + v[r];
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        hash_block[hash_fill] = b;
        if (hash_fill == 6'd63)
        begin
            compress_hash_block();
            hash_bits = hash_bits + 64'd512;
            hash_fill = '0;
        end
        else
            hash_fill = hash_fill + 6'd1;
    endfunction

    // pad, compress, queue the eight digest words, start a new message
    function automatic void finish_message();
        logic [63:0] total;
        digest_entry_t e;
        int i;
        total = hash_bits + 64'(hash_fill) * 64'd8;
        i = int'(hash_fill);
        hash_block[i] = 8'h80;
        i++;
        // no room for the length field: padding spills into an extra block
        if (hash_fill >= 6'd56)
        begin
            while (i < 64)
            begin
                hash_block[i] = 8'h00;
                i++;
            end
            compress_hash_block();
            i = 0;
        end
        while (i < 56)
        begin
            hash_block[i] = 8'h00;
            i++;
        end
        // big-endian bit length in the last eight bytes
        for (i = 0; i < 8; i++)
            hash_block[63 - i] = total[8 * i +: 8];
        compress_hash_block();
        for (i = 0; i < 8; i++)
        begin
            e.digest_word = hash_chain[i];
            e.word_index  = 3'(i);
            e.last_word   = (i == 7);
            owed_digest_words.push_back(e);
        end
        digests_owed++;
        restart_hash();
    endfunction

    // ------------------------------------------------------------------------
    // message channel driver: called at a falling edge, returns at one
    // ------------------------------------------------------------------------
    task automatic send_word(input logic word_kind, input logic [7:0] word_byte);
        // idle cycles before this word, drawn cycle by cycle
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(negedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.kind      <= word_kind;
        msg_ch.data_byte <= word_byte;
        @(posedge clk);
        while (msg_ch.ready !== 1'b1)
            @(posedge clk);
        // word taken at this edge: advance the model
        if (word_kind == KIND_FINISH)
            finish_message();
        else
            absorb_byte(word_byte);
        words_sent++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // digest receiver: ready drawn at each falling edge
    // ------------------------------------------------------------------------
    initial
    begin
        dig_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            dig_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // digest checker and handshake watchdog counter
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : digest_check
        digest_entry_t want;
        logic msg_taken;
        logic dig_taken;
        msg_taken = (msg_ch.valid === 1'b1) && (msg_ch.ready === 1'b1);
        dig_taken = rst_n && (dig_ch.valid === 1'b1) && (dig_ch.ready === 1'b1);
        if (dig_taken)
        begin
            if (owed_digest_words.size() == 0)
            begin
                $error("digest word %h with index %0d arrived with none owed",
                       dig_ch.digest_word, dig_ch.word_index);
                fail_count++;
            end
            else
            begin
                want = owed_digest_words.pop_front();
                if (dig_ch.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, got %h",
                           want.digest_word, dig_ch.digest_word);
                    fail_count++;
                end
                if (dig_ch.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, dig_ch.word_index);
                    fail_count++;
                end
                if (dig_ch.last_word !== want.last_word)
                begin
                    $error("last_word: expected %b, got %b",
                           want.last_word, dig_ch.last_word);
                    fail_count++;
                end
            end
        end
        if (msg_taken || dig_taken)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // a hung handshake ends the run
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // finish with nothing absorbed: digest of the empty message
    task automatic test_empty_message();
        send_word(KIND_FINISH, 8'($urandom_range(255)));
    endtask

    // two finishes in a row: the second one also hashes an empty message
    task automatic test_back_to_back_finish();
        send_word(KIND_ABSORB, 8'h5a);
        send_word(KIND_FINISH, 8'($urandom_range(255)));
        send_word(KIND_FINISH, 8'($urandom_range(255)));
    endtask

    // the classic "abc" vector
    task automatic test_short_string();
        send_word(KIND_ABSORB, 8'h61);
        send_word(KIND_ABSORB, 8'h62);
        send_word(KIND_ABSORB, 8'h63);
        send_word(KIND_FINISH, 8'hff);
    endtask

    // byte extremes and alternating patterns, every data bit both ways
    task automatic test_byte_extremes();
        send_word(KIND_ABSORB, 8'h00);
        send_word(KIND_ABSORB, 8'hff);
        send_word(KIND_ABSORB, 8'h55);
        send_word(KIND_ABSORB, 8'haa);
        send_word(KIND_ABSORB, 8'h80);
        send_word(KIND_ABSORB, 8'h01);
        send_word(KIND_FINISH, 8'h00);
    endtask

    // random messages; the idling pattern rotates with each message
    task automatic test_random_messages();
        int msg_no;
        int msg_len;
        int pick;
        msg_no = 0;
        while (words_sent < RANDOM_WORDS || digests_owed < RANDOM_DIGESTS)
        begin
            case (msg_no % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            // mostly short messages, many near the padding edges, a few
            // spanning two blocks
            pick = $urandom_range(99);
            if (pick < 55)
                msg_len = $urandom_range(12);
            else if (pick < 90)
                msg_len = EDGE_LEN[$urandom_range(5)];
            else
                msg_len = $urandom_range(121, 119);
            for (int j = 0; j < msg_len; j++)
            begin
                // stray finish now and then cuts the message short
                if ($urandom_range(99) < 3)
                    send_word(KIND_FINISH, 8'($urandom_range(255)));
                else
                    send_word(KIND_ABSORB, 8'($urandom_range(255)));
            end
            send_word(KIND_FINISH, 8'($urandom_range(255)));
            msg_no++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        msg_ch.valid     = 1'b0;
        msg_ch.kind      = KIND_ABSORB;
        msg_ch.data_byte = 8'h00;
        restart_hash();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part with both channels running flat out
        test_empty_message();
        test_back_to_back_finish();
        test_short_string();
        test_byte_extremes();

        test_random_messages();
        msg_ch.valid <= 1'b0;

        // drain the digest channel under the last idling pattern of the random part
        while (owed_digest_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
